### design/rhms_pkg.sv
// shared constants and pipeline word types for the ring hop move selector
package rhms_pkg;

    localparam int NUM_ORBITALS = 32;
    localparam int HOP_DIST     = 2;
    localparam int OCC_W        = 32;
    localparam int HOP_W        = 7;
    localparam int OUT_POS_W    = 5;
    localparam int POS_W        = $clog2(NUM_ORBITALS);
    localparam int SIDE_W       = $clog2(NUM_ORBITALS + 1);
    localparam int CNT_W        = $clog2(2 * NUM_ORBITALS + 1);

    // word moving down the counting chain
    typedef struct packed {
        logic [OCC_W-1:0]        occ;
        logic [OCC_W-1:0]        draw;
        logic [NUM_ORBITALS-1:0] lmask;
        logic [NUM_ORBITALS-1:0] rmask;
        logic [SIDE_W-1:0]       nleft;
        logic [SIDE_W-1:0]       nright;
    } cnt_word_t;

    // word moving down the selection chain
    typedef struct packed {
        logic [OCC_W-1:0]        occ;
        logic [NUM_ORBITALS-1:0] sel;
        logic [CNT_W-1:0]        total;
        logic [CNT_W-1:0]        k;
        logic [CNT_W-1:0]        seen;
        logic                    right;
        logic                    found;
        logic [POS_W-1:0]        pos;
        logic [POS_W-1:0]        from;
    } pick_word_t;

    // finished result word
    typedef struct packed {
        logic [OCC_W-1:0]     new_occupancy;
        logic [HOP_W-1:0]     hop_count;
        logic [OUT_POS_W-1:0] from_position;
        logic [OUT_POS_W-1:0] to_position;
        logic                 hop_right;
        logic                 no_move;
    } res_word_t;

endpackage

### design/rhms_count_cell.sv
// counting cell: adds one orbital's left and right candidate bits to the running totals
module rhms_count_cell
    import rhms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      prev_valid,
    input  cnt_word_t prev_word,
    output logic      this_valid,
    output cnt_word_t this_word
);

    logic      valid_reg;
    cnt_word_t word_reg;
    cnt_word_t word_next;

    always_comb
    begin
        word_next        = prev_word;
        word_next.nleft  = prev_word.nleft + SIDE_W'(prev_word.lmask[0]);
        word_next.nright = prev_word.nright + SIDE_W'(prev_word.rmask[0]);
        // next cell looks at the next orbital through bit zero; rotating keeps
        // the masks whole at the end of the chain
        word_next.lmask  = {prev_word.lmask[0], prev_word.lmask[NUM_ORBITALS-1:1]};
        word_next.rmask  = {prev_word.rmask[0], prev_word.rmask[NUM_ORBITALS-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign this_valid = valid_reg;
    assign this_word  = word_reg;

endmodule

### design/rhms_pick_cell.sv
// selection cell: checks one orbital and latches it when it is the k-th candidate
module rhms_pick_cell
    import rhms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       prev_valid,
    input  pick_word_t prev_word,
    output logic       this_valid,
    output pick_word_t this_word
);

    logic       valid_reg;
    pick_word_t word_reg;
    pick_word_t word_next;

    always_comb
    begin
        word_next = prev_word;
        if (prev_word.sel[0] && !prev_word.found)
        begin
            if (prev_word.seen == prev_word.k)
            begin
                word_next.found = 1'b1;
                word_next.from  = prev_word.pos;
            end
            else
            begin
                word_next.seen = prev_word.seen + CNT_W'(1);
            end
        end
        word_next.sel = prev_word.sel >> 1;
        word_next.pos = prev_word.pos + POS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign this_valid = valid_reg;
    assign this_word  = word_reg;

endmodule

### design/ring_hop_move_selector.sv
// top level: proposes one two-position hop on a ring of spin orbitals per word
//
// input channel: occupancy and random_draw, taken when in_valid is high and
// in_stall is low. output channel: new_occupancy, hop_count, from_position,
// to_position, hop_right and no_move, taken when out_valid is high and
// out_stall is low.
// a word runs through a chain of NUM_ORBITALS counting cells, a scaling
// stage (draw times count), a direction stage and a chain of NUM_ORBITALS
// selection cells, then lands in a two-entry output buffer.
// one word is accepted every cycle while the output buffer has room.
// when the receiver stalls the buffer fills; once both entries are held the
// whole pipeline freezes and in_stall rises, and it falls again the cycle
// after a result is taken. in_stall comes from a register only.
// reset empties the pipeline and the buffer; no item is lost or repeated.
module ring_hop_move_selector
    import rhms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OCC_W-1:0]     occupancy,
    input  logic [OCC_W-1:0]     random_draw,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [OCC_W-1:0]     new_occupancy,
    output logic [HOP_W-1:0]     hop_count,
    output logic [OUT_POS_W-1:0] from_position,
    output logic [OUT_POS_W-1:0] to_position,
    output logic                 hop_right,
    output logic                 no_move
);

    localparam logic [POS_W:0] RING_N = (POS_W + 1)'(NUM_ORBITALS);
    localparam logic [POS_W:0] STEP   = (POS_W + 1)'(HOP_DIST);

    logic en;
    logic accept;

    logic [NUM_ORBITALS:0] cnt_valid;
    cnt_word_t             cnt_word [NUM_ORBITALS+1];
    logic [NUM_ORBITALS:0] pick_valid;
    pick_word_t            pick_word [NUM_ORBITALS+1];

    logic [NUM_ORBITALS-1:0] ring;

    // scaling stage
    logic                      scale_valid_reg;
    logic [OCC_W-1:0]          scale_occ_reg;
    logic [NUM_ORBITALS-1:0]   scale_lmask_reg;
    logic [NUM_ORBITALS-1:0]   scale_rmask_reg;
    logic [SIDE_W-1:0]         scale_nleft_reg;
    logic [CNT_W-1:0]          scale_total_reg;
    logic [CNT_W-1:0]          scale_k_reg;
    logic [CNT_W-1:0]          total_next;
    logic [OCC_W+CNT_W-1:0]    product;

    // direction stage
    logic       dir_valid_reg;
    pick_word_t dir_word_reg;
    pick_word_t dir_word_next;

    // final result and output buffer
    pick_word_t       last;
    res_word_t        res_next;
    logic [POS_W:0]   from_x;
    logic [POS_W:0]   to_x;
    logic [POS_W-1:0] to_pos;

    res_word_t  slot0_reg;
    res_word_t  slot1_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign en       = (count_reg != 2'd2);
    assign in_stall = !en;
    assign accept   = in_valid && en;

    // candidate masks at the entry
    always_comb
    begin
        for (int i = 0; i < NUM_ORBITALS; i++)
        begin
            ring[i] = (i < OCC_W) ? occupancy[i % OCC_W] : 1'b0;
        end
        cnt_word[0].occ    = occupancy;
        cnt_word[0].draw   = random_draw;
        cnt_word[0].nleft  = '0;
        cnt_word[0].nright = '0;
        for (int i = 0; i < NUM_ORBITALS; i++)
        begin
            cnt_word[0].lmask[i] = ring[i]
                && !ring[(i + NUM_ORBITALS - HOP_DIST) % NUM_ORBITALS];
            cnt_word[0].rmask[i] = ring[i] && !ring[(i + HOP_DIST) % NUM_ORBITALS];
        end
    end
    assign cnt_valid[0] = accept;

    for (genvar g = 0; g < NUM_ORBITALS; g++)
    begin : g_count
        rhms_count_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .prev_valid (cnt_valid[g]),
            .prev_word  (cnt_word[g]),
            .this_valid (cnt_valid[g+1]),
            .this_word  (cnt_word[g+1])
        );
    end

    // candidate index = floor(draw * count / 2^32)
    assign total_next = CNT_W'(cnt_word[NUM_ORBITALS].nleft)
                      + CNT_W'(cnt_word[NUM_ORBITALS].nright);
    assign product = (OCC_W + CNT_W)'(cnt_word[NUM_ORBITALS].draw)
                   * (OCC_W + CNT_W)'(total_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_valid_reg <= 1'b0;
            dir_valid_reg   <= 1'b0;
        end
        else if (en)
        begin
            scale_valid_reg <= cnt_valid[NUM_ORBITALS];
            dir_valid_reg   <= scale_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            scale_occ_reg   <= cnt_word[NUM_ORBITALS].occ;
            scale_lmask_reg <= cnt_word[NUM_ORBITALS].lmask;
            scale_rmask_reg <= cnt_word[NUM_ORBITALS].rmask;
            scale_nleft_reg <= cnt_word[NUM_ORBITALS].nleft;
            scale_total_reg <= total_next;
            scale_k_reg     <= product[OCC_W +: CNT_W];
            dir_word_reg    <= dir_word_next;
        end
    end

    // left list first: indexes past it fall into the right list
    always_comb
    begin
        dir_word_next       = '0;
        dir_word_next.occ   = scale_occ_reg;
        dir_word_next.total = scale_total_reg;
        if (scale_k_reg < CNT_W'(scale_nleft_reg))
        begin
            dir_word_next.right = 1'b0;
            dir_word_next.k     = scale_k_reg;
            dir_word_next.sel   = scale_lmask_reg;
        end
        else
        begin
            dir_word_next.right = 1'b1;
            dir_word_next.k     = scale_k_reg - CNT_W'(scale_nleft_reg);
            dir_word_next.sel   = scale_rmask_reg;
        end
    end

    assign pick_valid[0] = dir_valid_reg;
    assign pick_word[0]  = dir_word_reg;

    for (genvar g = 0; g < NUM_ORBITALS; g++)
    begin : g_pick
        rhms_pick_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .prev_valid (pick_valid[g]),
            .prev_word  (pick_word[g]),
            .this_valid (pick_valid[g+1]),
            .this_word  (pick_word[g+1])
        );
    end

    assign last   = pick_word[NUM_ORBITALS];
    assign from_x = {1'b0, last.from};

    // two positions along the ring with wrap
    always_comb
    begin
        if (last.right)
        begin
            to_x = (from_x + STEP >= RING_N) ? from_x + STEP - RING_N : from_x + STEP;
        end
        else
        begin
            to_x = (from_x >= STEP) ? from_x - STEP : from_x + RING_N - STEP;
        end
    end
    assign to_pos = to_x[POS_W-1:0];

    always_comb
    begin
        res_next = '0;
        if (last.total == '0)
        begin
            res_next.new_occupancy = last.occ;
            res_next.no_move       = 1'b1;
        end
        else
        begin
            for (int b = 0; b < OCC_W; b++)
            begin
                if (b == int'(to_pos))
                begin
                    res_next.new_occupancy[b] = 1'b1;
                end
                else if (b == int'(last.from))
                begin
                    res_next.new_occupancy[b] = 1'b0;
                end
                else
                begin
                    res_next.new_occupancy[b] = last.occ[b];
                end
            end
            res_next.hop_count     = HOP_W'(last.total);
            res_next.from_position = OUT_POS_W'(last.from);
            res_next.to_position   = OUT_POS_W'(to_pos);
            res_next.hop_right     = last.right;
        end
    end

    // two-entry output buffer
    assign push = en && pick_valid[NUM_ORBITALS];
    assign pop  = (count_reg != 2'd0) && !out_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (count_reg == 2'd2)
            begin
                slot0_reg <= slot1_reg;
            end
            else if (push)
            begin
                slot0_reg <= res_next;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_reg <= res_next;
            end
            else
            begin
                slot1_reg <= res_next;
            end
        end
    end

    assign out_valid     = (count_reg != 2'd0);
    assign new_occupancy = slot0_reg.new_occupancy;
    assign hop_count     = slot0_reg.hop_count;
    assign from_position = slot0_reg.from_position;
    assign to_position   = slot0_reg.to_position;
    assign hop_right     = slot0_reg.hop_right;
    assign no_move       = slot0_reg.no_move;

endmodule
